### rtl/mmbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbd_pkg: shared types and constants of the memory map bus decoder
// Holds the address map, the region and status codes and the store request.
// ----------------------------------------------------------------------------
package mmbd_pkg;

    localparam int ROM_BYTES    = 49152;
    localparam int RAM_BYTES    = 2048;
    localparam int IO_ONE_BYTES = 224;
    localparam int IO_TWO_BYTES = 128;

    localparam int ROM_AW  = $clog2(ROM_BYTES);
    localparam int RAM_AW  = $clog2(RAM_BYTES);
    localparam int IO1_AW  = $clog2(IO_ONE_BYTES);
    localparam int IO2_AW  = $clog2(IO_TWO_BYTES);
    localparam int ADDR_W  = 16;

    localparam logic [ADDR_W-1:0] ROM_TOP   = 16'hBFFF;
    localparam logic [ADDR_W-1:0] IO1_BASE  = 16'hF020;
    localparam logic [ADDR_W-1:0] IO1_TOP   = 16'hF0FF;
    localparam logic [ADDR_W-1:0] RAM_BASE  = 16'hF780;
    localparam logic [ADDR_W-1:0] RAM_TOP   = 16'hFF7F;
    localparam logic [ADDR_W-1:0] IO2_BASE  = 16'hFF80;
    localparam logic [ADDR_W-1:0] ADDR_TOP  = 16'hFFFF;
    localparam logic [ADDR_W-1:0] ADDR_NEAR = 16'hFFFE;
    localparam logic [7:0]        UNMAPPED_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        REG_NONE,
        REG_ROM,
        REG_IO1,
        REG_RAM,
        REG_IO2
    } t_region;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_PAST_TOP = 2'd2,
        ST_HALTED   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2,
        SZ_NONE = 2'd3
    } t_size;

    typedef struct packed {
        logic              clr;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    function automatic t_region decode_region(input logic [ADDR_W-1:0] a);
        t_region r;
        r = REG_NONE;
        if (a <= ROM_TOP) begin
            r = REG_ROM;
        end else if (a >= IO1_BASE && a <= IO1_TOP) begin
            r = REG_IO1;
        end else if (a >= RAM_BASE && a <= RAM_TOP) begin
            r = REG_RAM;
        end else if (a >= IO2_BASE) begin
            r = REG_IO2;
        end
        return r;
    endfunction

endpackage

### rtl/mmbd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbd_ifs: request and response channels of the bus decoder
// Valid/ready channels carrying one bus request and its response.
// ----------------------------------------------------------------------------
interface mmbd_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [1:0]  size;
    logic [15:0] address;
    logic [31:0] write_data;

    modport source (output valid, output action, output size, output address,
                    output write_data, input ready);
    modport sink   (input valid, input action, input size, input address,
                    input write_data, output ready);
endinterface

interface mmbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [1:0]  status;

    modport source (output valid, output read_data, output status, input ready);
    modport sink   (input valid, input read_data, input status, output ready);
endinterface

### rtl/mmbd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbd_store: byte-wide backing stores of the address map
// ROM, RAM and the two I/O areas, one byte port, registered read data.
// ----------------------------------------------------------------------------
module mmbd_store (
    input  logic               i_clk,
    input  mmbd_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);

    logic [7:0] rom [0:mmbd_pkg::ROM_BYTES-1];
    logic [7:0] io1 [0:mmbd_pkg::IO_ONE_BYTES-1];
    logic [7:0] ram [0:mmbd_pkg::RAM_BYTES-1];
    logic [7:0] io2 [0:mmbd_pkg::IO_TWO_BYTES-1];

    mmbd_pkg::t_region           region;
    mmbd_pkg::t_region           r_region;
    logic [mmbd_pkg::ROM_AW-1:0] rom_idx;
    logic [mmbd_pkg::IO1_AW-1:0] io1_idx;
    logic [mmbd_pkg::RAM_AW-1:0] ram_idx;
    logic [mmbd_pkg::IO2_AW-1:0] io2_idx;
    logic                        rom_we;
    logic                        io1_we;
    logic                        ram_we;
    logic                        io2_we;
    logic [7:0]                  wdata;
    logic [7:0]                  r_rom_q;
    logic [7:0]                  r_io1_q;
    logic [7:0]                  r_ram_q;
    logic [7:0]                  r_io2_q;

    always_comb begin
        region = mmbd_pkg::decode_region(i_req.addr);
        wdata  = i_req.clr ? 8'h00 : i_req.wdata;
        rom_idx = i_req.addr[mmbd_pkg::ROM_AW-1:0];
        if (i_req.clr) begin
            io1_idx = i_req.addr[mmbd_pkg::IO1_AW-1:0];
            ram_idx = i_req.addr[mmbd_pkg::RAM_AW-1:0];
            io2_idx = i_req.addr[mmbd_pkg::IO2_AW-1:0];
            rom_we  = 1'b0;
            io1_we  = i_req.addr < 16'(mmbd_pkg::IO_ONE_BYTES);
            ram_we  = 1'b1;
            io2_we  = i_req.addr < 16'(mmbd_pkg::IO_TWO_BYTES);
        end else begin
            io1_idx = mmbd_pkg::IO1_AW'(i_req.addr - mmbd_pkg::IO1_BASE);
            ram_idx = mmbd_pkg::RAM_AW'(i_req.addr - mmbd_pkg::RAM_BASE);
            io2_idx = mmbd_pkg::IO2_AW'(i_req.addr - mmbd_pkg::IO2_BASE);
            rom_we  = i_req.wr && region == mmbd_pkg::REG_ROM;
            io1_we  = i_req.wr && region == mmbd_pkg::REG_IO1;
            ram_we  = i_req.wr && region == mmbd_pkg::REG_RAM;
            io2_we  = i_req.wr && region == mmbd_pkg::REG_IO2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rom_we) begin
            rom[rom_idx] <= wdata;
        end
        r_rom_q <= rom[rom_idx];
    end

    always_ff @(posedge i_clk) begin
        if (io1_we) begin
            io1[io1_idx] <= wdata;
        end
        r_io1_q <= io1[io1_idx];
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            ram[ram_idx] <= wdata;
        end
        r_ram_q <= ram[ram_idx];
    end

    always_ff @(posedge i_clk) begin
        if (io2_we) begin
            io2[io2_idx] <= wdata;
        end
        r_io2_q <= io2[io2_idx];
    end

    always_ff @(posedge i_clk) begin
        r_region <= region;
    end

    always_comb begin
        unique case (r_region)
            mmbd_pkg::REG_ROM: o_rdata = r_rom_q;
            mmbd_pkg::REG_IO1: o_rdata = r_io1_q;
            mmbd_pkg::REG_RAM: o_rdata = r_ram_q;
            mmbd_pkg::REG_IO2: o_rdata = r_io2_q;
            default:           o_rdata = mmbd_pkg::UNMAPPED_BYTE;
        endcase
    end

endmodule

### rtl/memory_map_bus_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_map_bus_decoder: big-endian byte-serial bus decoder
// Maps 1, 2 or 4 byte accesses onto ROM, RAM and two I/O areas.
// ----------------------------------------------------------------------------
// After reset the block clears RAM and the I/O areas and takes no request until
// that pass is over. Each request is then handled one byte at a time through a
// single byte-wide store port; a faulting write ends early, and a request to a
// halted block or of size three goes straight to the response. The response
// sits in an output register, so the next request is taken while a response
// still waits.
// ----------------------------------------------------------------------------
module memory_map_bus_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmbd_req_if.sink   i_req,
    mmbd_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_COLLECT,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [mmbd_pkg::RAM_AW-1:0] r_clr;
    logic                        r_action;
    logic [15:0]                 r_addr;
    logic [1:0]                  r_cnt;
    logic [1:0]                  r_last;
    logic [31:0]                 r_wdata;
    logic [31:0]                 r_rdata;
    logic [1:0]                  r_status;
    logic                        r_halted;
    logic                        r_out_valid;
    logic [31:0]                 r_out_data;
    logic [1:0]                  r_out_status;

    mmbd_pkg::t_mem_req mem_req;
    logic [7:0]         mem_rdata;
    logic               mapped;
    logic               past_top;
    logic               accept;
    logic               out_free;

    mmbd_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        accept   = i_req.valid && r_state == S_IDLE;
        out_free = !r_out_valid || o_rsp.ready;
        mapped   = mmbd_pkg::decode_region(r_addr) != mmbd_pkg::REG_NONE;
        past_top = r_last != 2'd0 &&
                   ((!r_cnt[0] && r_addr == mmbd_pkg::ADDR_TOP) ||
                    (r_cnt == 2'd0 && r_last == 2'd3 &&
                     r_addr == mmbd_pkg::ADDR_NEAR));
        mem_req.clr   = r_state == S_CLEAR;
        mem_req.wr    = r_state == S_ACCESS && r_action && mapped && !past_top;
        mem_req.addr  = (r_state == S_CLEAR) ? 16'(r_clr) : r_addr;
        mem_req.wdata = r_wdata[31:24];
    end

    assign i_req.ready     = r_state == S_IDLE;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;
    assign o_rsp.status    = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_halted     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_data   <= '0;
            r_out_status <= mmbd_pkg::ST_OK;
        end else begin
            if (r_out_valid && o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == mmbd_pkg::RAM_AW'(mmbd_pkg::RAM_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_action <= i_req.action;
                        r_addr   <= i_req.address;
                        r_cnt    <= 2'd0;
                        r_rdata  <= '0;
                        r_status <= mmbd_pkg::ST_OK;
                        case (i_req.size)
                            mmbd_pkg::SZ_BYTE: begin
                                r_last  <= 2'd0;
                                r_wdata <= i_req.write_data << 24;
                            end
                            mmbd_pkg::SZ_HALF: begin
                                r_last  <= 2'd1;
                                r_wdata <= i_req.write_data << 16;
                            end
                            default: begin
                                r_last  <= 2'd3;
                                r_wdata <= i_req.write_data;
                            end
                        endcase
                        if (r_halted) begin
                            r_status <= mmbd_pkg::ST_HALTED;
                            r_state  <= S_DONE;
                        end else if (i_req.size == mmbd_pkg::SZ_NONE) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_ACCESS;
                        end
                    end
                end
                S_ACCESS: begin
                    if (!r_action) begin
                        r_state <= S_COLLECT;
                    end else if (past_top) begin
                        r_status <= mmbd_pkg::ST_PAST_TOP;
                        r_halted <= 1'b1;
                        r_state  <= S_DONE;
                    end else if (!mapped) begin
                        r_status <= mmbd_pkg::ST_UNMAPPED;
                        r_halted <= 1'b1;
                        r_state  <= S_DONE;
                    end else if (r_cnt == r_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_addr  <= r_addr + 1'b1;
                        r_wdata <= r_wdata << 8;
                    end
                end
                S_COLLECT: begin
                    r_rdata <= {r_rdata[23:0], mem_rdata};
                    if (r_cnt == r_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_ACCESS;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= r_rdata;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("Halt flag cleared without reset.");

    a_write_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr |-> mmbd_pkg::decode_region(mem_req.addr) != mmbd_pkg::REG_NONE)
        else $error("Store write issued to an unmapped address.");

    a_halted_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == mmbd_pkg::ST_HALTED |-> r_halted)
        else $error("Halted status reported while the block is running.");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != mmbd_pkg::ST_OK |-> r_out_data == '0)
        else $error("Faulted request returned non-zero read data.");

    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |-> !mem_req.wr && !mem_req.clr)
        else $error("Store busy while a new request is taken.");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the memory map bus decoder
// Drives reads, writes and no-op requests of every width over the whole address
// map and checks each response against a byte image of the map. The sender
// works in bursts and the receiver stalls. The run ends with one write fault
// chosen at random, followed by requests to the halted block.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RANDOM_ACCESSES = 950;
    localparam int HOLD_AFTER      = 300;
    localparam int HOLD_CYCLES     = 400;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam int AREA_ROM = 0;
    localparam int AREA_IO1 = 1;
    localparam int AREA_RAM = 2;

    typedef struct {
        bit              drain_first;
        logic            action;
        mmbd_pkg::t_size size;
        logic [15:0]     address;
        logic [31:0]     write_data;
    } t_access;

    typedef struct {
        logic [31:0]       read_data;
        mmbd_pkg::t_status status;
    } t_reply;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mmbd_req_if req_ch ();
    mmbd_rsp_if rsp_ch ();

    memory_map_bus_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    t_access     access_queue[$];
    t_reply      due_replies[$];
    t_access     in_flight;
    t_reply      due_now;
    bit          sending;
    int          burst_left;
    int          gap_left;

    logic [7:0]  mem_img [0:65535];
    bit          halted;
    bit          rom_seen [0:mmbd_pkg::ROM_BYTES-1];

    int          err_cnt;
    int          idle_cycles;
    int          reply_cnt;
    int          hold_left;
    bit          hold_done;
    int          stall_mode;
    int          mode_left;
    int          stall_phase;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic bit byte_mapped(input logic [15:0] a);
        return (a <= mmbd_pkg::ROM_TOP) ||
               (a >= mmbd_pkg::IO1_BASE && a <= mmbd_pkg::IO1_TOP) ||
               (a >= mmbd_pkg::RAM_BASE && a <= mmbd_pkg::RAM_TOP) ||
               (a >= mmbd_pkg::IO2_BASE);
    endfunction

    function automatic bit poke(input logic [15:0] a, input logic [7:0] v);
        if (!byte_mapped(a)) begin
            return 1'b0;
        end
        mem_img[a] = v;
        return 1'b1;
    endfunction

    function automatic mmbd_pkg::t_status poke_half(input logic [15:0] a,
                                                    input logic [15:0] v);
        if (a == mmbd_pkg::ADDR_TOP) begin
            return mmbd_pkg::ST_PAST_TOP;
        end
        if (!poke(a, v[15:8])) begin
            return mmbd_pkg::ST_UNMAPPED;
        end
        if (!poke(a + 16'd1, v[7:0])) begin
            return mmbd_pkg::ST_UNMAPPED;
        end
        return mmbd_pkg::ST_OK;
    endfunction

    function automatic t_reply emulate_access(input t_access acc);
        t_reply      r;
        logic [15:0] a;
        logic [7:0]  b;
        int          i;
        r.read_data = '0;
        r.status    = mmbd_pkg::ST_OK;
        if (halted) begin
            r.status = mmbd_pkg::ST_HALTED;
            return r;
        end
        if (acc.size == mmbd_pkg::SZ_NONE) begin
            return r;
        end
        if (acc.action == ACT_READ) begin
            a = acc.address;
            for (i = 0; i < (1 << acc.size); i++) begin
                b = byte_mapped(a) ? mem_img[a] : mmbd_pkg::UNMAPPED_BYTE;
                r.read_data = {r.read_data[23:0], b};
                a = a + 16'd1;
            end
        end else begin
            case (acc.size)
                mmbd_pkg::SZ_BYTE: begin
                    if (!poke(acc.address, acc.write_data[7:0])) begin
                        r.status = mmbd_pkg::ST_UNMAPPED;
                    end
                end
                mmbd_pkg::SZ_HALF: begin
                    r.status = poke_half(acc.address, acc.write_data[15:0]);
                end
                default: begin
                    if (acc.address == mmbd_pkg::ADDR_TOP ||
                        acc.address == mmbd_pkg::ADDR_NEAR) begin
                        r.status = mmbd_pkg::ST_PAST_TOP;
                    end else begin
                        r.status = poke_half(acc.address, acc.write_data[31:16]);
                        if (r.status == mmbd_pkg::ST_OK) begin
                            r.status = poke_half(acc.address + 16'd2,
                                                 acc.write_data[15:0]);
                        end
                    end
                end
            endcase
        end
        if (r.status != mmbd_pkg::ST_OK) begin
            halted = 1'b1;
        end
        return r;
    endfunction

    function automatic void queue_access(input bit drain, input logic act,
                                         input mmbd_pkg::t_size sz,
                                         input logic [15:0] addr, input logic [31:0] data);
        t_access     acc;
        logic [15:0] a;
        int          i;
        acc = '{drain, act, sz, addr, data};
        access_queue.push_back(acc);
        if (act == ACT_WRITE && sz != mmbd_pkg::SZ_NONE) begin
            a = addr;
            for (i = 0; i < (1 << sz); i++) begin
                if (a <= mmbd_pkg::ROM_TOP) begin
                    rom_seen[a] = 1'b1;
                end
                a = a + 16'd1;
            end
        end
    endfunction

    // ROM bytes that have never been written hold no defined value.
    function automatic bit read_is_safe(input logic [15:0] addr, input mmbd_pkg::t_size sz);
        logic [15:0] a;
        int          i;
        a = addr;
        for (i = 0; i < (1 << sz); i++) begin
            if (a <= mmbd_pkg::ROM_TOP && !rom_seen[a]) begin
                return 1'b0;
            end
            a = a + 16'd1;
        end
        return 1'b1;
    endfunction

    function automatic logic [15:0] span_in(input int area, input int n);
        int lo;
        int hi;
        int pick;
        case (area)
            AREA_ROM: begin
                lo = 0;
                hi = mmbd_pkg::ROM_TOP;
            end
            AREA_IO1: begin
                lo = mmbd_pkg::IO1_BASE;
                hi = mmbd_pkg::IO1_TOP;
            end
            AREA_RAM: begin
                lo = mmbd_pkg::RAM_BASE;
                hi = mmbd_pkg::RAM_TOP;
            end
            default: begin
                lo = mmbd_pkg::IO2_BASE;
                hi = mmbd_pkg::ADDR_TOP;
            end
        endcase
        hi = hi - n + 1;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 16'(lo);
        end else if (pick == 1) begin
            return 16'(hi);
        end else if (pick < 5) begin
            return 16'(lo + $urandom_range(0, 31));
        end else if (pick < 8) begin
            return 16'(hi - $urandom_range(0, 31));
        end
        return 16'($urandom_range(lo, hi));
    endfunction

    function automatic logic [15:0] border_addr();
        logic [15:0] b;
        case ($urandom_range(0, 5))
            0:       b = 16'h0000;
            1:       b = mmbd_pkg::ROM_TOP + 16'd1;
            2:       b = mmbd_pkg::IO1_BASE;
            3:       b = mmbd_pkg::IO1_TOP + 16'd1;
            4:       b = mmbd_pkg::RAM_BASE;
            default: b = mmbd_pkg::IO2_BASE;
        endcase
        return b - 16'($urandom_range(0, 3));
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            req_ch.valid <= 1'b0;
        end else if (!sending) begin
            if (gap_left > 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (access_queue.size() != 0 &&
                         !(access_queue[0].drain_first && due_replies.size() != 0)) begin
                in_flight = access_queue.pop_front();
                req_ch.action     <= in_flight.action;
                req_ch.size       <= in_flight.size;
                req_ch.address    <= in_flight.address;
                req_ch.write_data <= in_flight.write_data;
                req_ch.valid      <= 1'b1;
                sending = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        stall_phase++;
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (!hold_done && reply_cnt >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            if (mode_left <= 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= (stall_phase % 5) != 0;
                default: rsp_ch.ready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            reply_cnt++;
            if (due_replies.size() == 0) begin
                err_cnt++;
                $display("%0t: response with none due, read_data %h status %0d",
                         $time, rsp_ch.read_data, rsp_ch.status);
            end else begin
                due_now = due_replies.pop_front();
                if (rsp_ch.read_data !== due_now.read_data) begin
                    err_cnt++;
                    $display("%0t: read_data expected %h, actual %h",
                             $time, due_now.read_data, rsp_ch.read_data);
                end
                if (rsp_ch.status !== due_now.status) begin
                    err_cnt++;
                    $display("%0t: status expected %0d, actual %0d",
                             $time, due_now.status, rsp_ch.status);
                end
            end
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            due_replies.push_back(emulate_access(in_flight));
            sending = 1'b0;
        end
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        int              k;
        int              roll;
        int              n;
        int              tries;
        bit              drain;
        mmbd_pkg::t_size sz;
        logic [15:0]     addr;

        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_READ;
        req_ch.size       = mmbd_pkg::SZ_BYTE;
        req_ch.address    = '0;
        req_ch.write_data = '0;
        rsp_ch.ready      = 1'b0;
        burst_left        = 1;
        foreach (mem_img[j]) begin
            mem_img[j] = 8'h00;
        end

        queue_access(1'b0, ACT_WRITE, mmbd_pkg::SZ_WORD, 16'h0000, 32'h0123_4567);
        queue_access(1'b0, ACT_WRITE, mmbd_pkg::SZ_WORD, mmbd_pkg::ROM_TOP - 16'd3,
                     32'hFFFF_FFFF);
        queue_access(1'b0, ACT_WRITE, mmbd_pkg::SZ_BYTE, mmbd_pkg::IO1_BASE, 32'h0000_00A5);
        queue_access(1'b0, ACT_WRITE, mmbd_pkg::SZ_BYTE, mmbd_pkg::IO1_TOP, 32'hFFFF_FF5A);
        queue_access(1'b0, ACT_WRITE, mmbd_pkg::SZ_HALF, mmbd_pkg::RAM_BASE, 32'h0000_BEEF);
        queue_access(1'b0, ACT_WRITE, mmbd_pkg::SZ_HALF, mmbd_pkg::RAM_TOP - 16'd1,
                     32'h0000_0000);
        queue_access(1'b0, ACT_WRITE, mmbd_pkg::SZ_WORD, mmbd_pkg::IO2_BASE, 32'hCAFE_F00D);
        queue_access(1'b0, ACT_WRITE, mmbd_pkg::SZ_WORD, mmbd_pkg::ADDR_TOP - 16'd3,
                     32'h89AB_CDEF);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_WORD, mmbd_pkg::ADDR_NEAR, 32'h0);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_HALF, mmbd_pkg::ADDR_TOP, 32'h0);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_HALF, mmbd_pkg::ROM_TOP, 32'h0);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_HALF, mmbd_pkg::IO1_BASE - 16'd1, 32'h0);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_BYTE, mmbd_pkg::ROM_TOP + 16'd1, 32'h0);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_WORD, mmbd_pkg::RAM_BASE - 16'd1, 32'h0);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_HALF, mmbd_pkg::IO1_TOP, 32'h0);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_HALF, mmbd_pkg::RAM_TOP, 32'h0);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_WORD, mmbd_pkg::RAM_BASE + 16'h0080,
                     32'h0);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_WORD, mmbd_pkg::IO1_BASE + 16'h0030,
                     32'h0);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_NONE, mmbd_pkg::ADDR_TOP, 32'hFFFF_FFFF);
        queue_access(1'b0, ACT_WRITE, mmbd_pkg::SZ_NONE, 16'h0000, 32'hFFFF_FFFF);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_WORD, 16'h0000, 32'h0);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_BYTE, mmbd_pkg::ROM_TOP, 32'h0);
        queue_access(1'b0, ACT_WRITE, mmbd_pkg::SZ_HALF, 16'h0001, 32'hFFFF_0000);
        queue_access(1'b0, ACT_READ, mmbd_pkg::SZ_WORD, mmbd_pkg::IO2_BASE, 32'h0);

        for (k = 0; k < RANDOM_ACCESSES; k++) begin
            drain = (k == RANDOM_ACCESSES / 2);
            roll  = $urandom_range(0, 99);
            sz    = mmbd_pkg::t_size'($urandom_range(0, 2));
            n     = 1 << sz;
            if (roll < 40) begin
                queue_access(drain, ACT_WRITE, sz, span_in($urandom_range(0, 3), n),
                             $urandom());
            end else if (roll < 93) begin
                if (roll < 80) begin
                    addr = span_in($urandom_range(0, 3), n);
                end else if (roll < 87) begin
                    addr = border_addr();
                end else begin
                    addr = 16'($urandom());
                end
                for (tries = 0; tries < 6 && !read_is_safe(addr, sz); tries++) begin
                    addr = span_in($urandom_range(0, 3), n);
                end
                if (!read_is_safe(addr, sz)) begin
                    addr = span_in(AREA_RAM, n);
                end
                queue_access(drain, ACT_READ, sz, addr, $urandom());
            end else begin
                queue_access(drain, 1'($urandom_range(0, 1)), mmbd_pkg::SZ_NONE,
                             16'($urandom()), $urandom());
            end
        end

        // One fatal write per run; the block stays halted until the end.
        case ($urandom_range(0, 6))
            0: begin
                sz   = mmbd_pkg::SZ_BYTE;
                addr = $urandom_range(0, 1) ?
                       16'($urandom_range(mmbd_pkg::ROM_TOP + 1, mmbd_pkg::IO1_BASE - 1)) :
                       16'($urandom_range(mmbd_pkg::IO1_TOP + 1, mmbd_pkg::RAM_BASE - 1));
            end
            1: begin
                sz   = mmbd_pkg::SZ_HALF;
                addr = mmbd_pkg::ROM_TOP;
            end
            2: begin
                sz   = mmbd_pkg::SZ_WORD;
                addr = mmbd_pkg::IO1_TOP - 16'd2;
            end
            3: begin
                sz   = mmbd_pkg::SZ_HALF;
                addr = mmbd_pkg::ADDR_TOP;
            end
            4: begin
                sz   = mmbd_pkg::SZ_WORD;
                addr = $urandom_range(0, 1) ? mmbd_pkg::ADDR_TOP : mmbd_pkg::ADDR_NEAR;
            end
            5: begin
                sz   = mmbd_pkg::SZ_WORD;
                addr = mmbd_pkg::ADDR_TOP - 16'd2;
            end
            default: begin
                sz   = mmbd_pkg::SZ_WORD;
                addr = 16'($urandom_range(mmbd_pkg::ROM_TOP + 1, mmbd_pkg::IO1_BASE - 4));
            end
        endcase
        queue_access(1'b1, ACT_WRITE, sz, addr, $urandom());
        for (k = 0; k < 16; k++) begin
            queue_access(1'b0, 1'($urandom_range(0, 1)),
                         mmbd_pkg::t_size'($urandom_range(0, 3)),
                         16'($urandom()), $urandom());
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while ((access_queue.size() != 0 || sending || due_replies.size() != 0) &&
               idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
        end
        if (idle_cycles < WATCHDOG_LIMIT) begin
            repeat (40) @(negedge i_clk);
        end else begin
            $display("%0t: watchdog expired with %0d responses outstanding",
                     $time, due_replies.size());
        end
        if (idle_cycles < WATCHDOG_LIMIT && err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### files.f
rtl/mmbd_pkg.sv
rtl/mmbd_ifs.sv
rtl/mmbd_store.sv
rtl/memory_map_bus_decoder.sv
dv/tb_top.sv
